>>> rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, switched off while arst_n is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Concurrent assertion sampled on clk that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/pcu_pkg.sv
`timescale 1ns / 1ps

package pcu_pkg;

	// Packing codes of the chroma_mode register.
	localparam logic [1:0] MODE_8BIT = 2'd0;
	localparam logic [1:0] MODE_4BIT = 2'd1;
	localparam logic [1:0] MODE_5BIT = 2'd2;
	localparam logic [1:0] MODE_RESET = MODE_5BIT;

	// Register indexes on the configuration port.
	localparam int unsigned PADDR_W = 3;
	localparam logic REG_MODE = 1'b0;

	// Result queue depth in sample pairs.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Control decoded once per item and shared by both lanes.
	typedef struct packed {
		logic clr;
		logic mode5;
		logic mode4;
		logic two;
		logic [3:0] sh0;
		logic [3:0] sh1;
		logic [2:0] rem;
	} pcu_ctl_t;

	typedef struct packed {
		logic [7:0] cb;
		logic [7:0] cr;
		logic last;
	} pcu_pair_t;

endpackage

>>> rtl/pcu_if.sv
`timescale 1ns / 1ps

interface pcu_in_if;
	logic valid;
	logic ready;
	logic [7:0] cb_byte;
	logic [7:0] cr_byte;
	logic restart;

	modport source (output valid, output cb_byte, output cr_byte, output restart, input ready);
	modport sink (input valid, input cb_byte, input cr_byte, input restart, output ready);
endinterface

interface pcu_out_if;
	logic valid;
	logic ready;
	logic [7:0] cb_sample;
	logic [7:0] cr_sample;
	logic last;

	modport source (output valid, output cb_sample, output cr_sample, output last,
		input ready);
	modport sink (input valid, input cb_sample, input cr_sample, input last,
		output ready);
endinterface

>>> rtl/packed_chroma_unpacker_top.sv
`timescale 1ns / 1ps
// Packed chroma unpacker.
// The ingress channel takes one request per packed byte pair: a Cb byte, the
// Cr byte at the same offset and a restart flag that marks a plane start.
// The egress channel delivers expanded (Cb, Cr) sample pairs; last is set on
// the final pair produced by a request. 8-bit mode gives one pair per
// request, 4-bit mode two, 5-bit mode one or two depending on how many
// leftover bits the previous byte left behind.
// chroma_mode is written over the APB port at byte address 0, and reads back
// there; the user must write it only while the block is idle, which the block
// itself does not enforce. An accepted request's pairs enter the result queue;
// with the queue empty, the first is on egress in the cycle after acceptance.
// Throughput is one pair per cycle while the egress receiver holds ready.
// A four-pair result queue lets the next request in while earlier pairs wait.
// Reset clears the leftover bits, the bit count and the queue, and sets
// chroma_mode to the 5-bit stream. When the receiver stalls, the queue fills
// and ingress ready drops once fewer than two slots are free.
module packed_chroma_unpacker_top (
	input  logic                        clk,
	input  logic                        arst_n,
	pcu_in_if.sink                      ingress,
	pcu_out_if.source                   egress,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pcu_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import pcu_pkg::*;

	logic       [1:0] mode_q;
	logic             reg_idx;
	logic             room;
	logic             push;
	pcu_ctl_t         ctl;
	logic       [7:0] cb0;
	logic       [7:0] cb1;
	logic       [7:0] cr0;
	logic       [7:0] cr1;

	// Configuration port: registers are one word apart, so bit 2 picks one.
	assign pready = 1'b1;
	assign reg_idx = paddr[2];
	assign prdata = (reg_idx == REG_MODE) ? {30'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_MODE) begin
			mode_q <= pwdata[1:0];
		end
	end

	// A request is taken whenever the result queue has room for two pairs.
	assign ingress.ready = room;
	assign push = ingress.valid && room;

	// Shared bit count and shift decode for both planes.
	pcu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (mode_q),
		.restart (ingress.restart),
		.push    (push),
		.ctl     (ctl)
	);

	// One lane per chroma plane; each keeps its own leftover bits.
	pcu_lane u_lane_cb (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.ctl     (ctl),
		.data    (ingress.cb_byte),
		.sample0 (cb0),
		.sample1 (cb1)
	);

	pcu_lane u_lane_cr (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.ctl     (ctl),
		.data    (ingress.cr_byte),
		.sample0 (cr0),
		.sample1 (cr1)
	);

	// The merge stage pairs the lane samples, tags last, and queues them.
	pcu_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.two    (ctl.two),
		.cb0    (cb0),
		.cb1    (cb1),
		.cr0    (cr0),
		.cr1    (cr1),
		.room   (room),
		.egress (egress)
	);

endmodule

>>> rtl/pcu_ctrl.sv
`timescale 1ns / 1ps

module pcu_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       mode,
	input  logic             restart,
	input  logic             push,
	output pcu_pkg::pcu_ctl_t ctl
);
	import pcu_pkg::*;

	logic [2:0] count_q;
	logic [2:0] count_eff;
	logic [3:0] n;
	logic [3:0] rem_w;

	// The bit count is shared by both planes since they advance in lockstep.
	always_comb begin
		count_eff = restart ? 3'd0 : count_q;
		n = {1'b0, count_eff} + 4'd8;
		ctl.clr = restart;
		ctl.mode5 = (mode == MODE_5BIT);
		ctl.mode4 = (mode == MODE_4BIT);
		ctl.sh0 = n - 4'd5;
		ctl.sh1 = n - 4'd10;
		if (ctl.mode5) begin
			ctl.two = (n >= 4'd10);
			rem_w = ctl.two ? (n - 4'd10) : (n - 4'd5);
		end else begin
			ctl.two = ctl.mode4;
			rem_w = 4'd0;
		end
		ctl.rem = rem_w[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd0;
		end else if (push) begin
			count_q <= ctl.rem;
		end
	end

endmodule

>>> rtl/pcu_lane.sv
`timescale 1ns / 1ps

module pcu_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pcu_pkg::pcu_ctl_t ctl,
	input  logic [7:0]        data,
	output logic [7:0]        sample0,
	output logic [7:0]        sample1
);
	import pcu_pkg::*;

	logic [3:0]  left_q;
	logic [3:0]  left_d;
	logic [11:0] acc;
	logic [11:0] sel0;
	logic [11:0] sel1;
	logic [5:0]  mask;

	always_comb begin
		acc = {(ctl.clr ? 4'd0 : left_q), data};
		sel0 = acc >> ctl.sh0;
		sel1 = acc >> ctl.sh1;
		mask = (6'd1 << ctl.rem) - 6'd1;
		if (ctl.mode5) begin
			sample0 = {sel0[4:0], 3'b000};
			sample1 = {sel1[4:0], 3'b000};
			left_d = acc[3:0] & mask[3:0];
		end else if (ctl.mode4) begin
			sample0 = {data[7:4], 4'b0000};
			sample1 = {data[3:0], 4'b0000};
			left_d = 4'd0;
		end else begin
			// 8-bit mode and the unused code both pass the byte through.
			sample0 = data;
			sample1 = data;
			left_d = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 4'd0;
		end else if (push) begin
			left_q <= left_d;
		end
	end

endmodule

>>> rtl/pcu_merge.sv
`timescale 1ns / 1ps

module pcu_merge (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       two,
	input  logic [7:0] cb0,
	input  logic [7:0] cb1,
	input  logic [7:0] cr0,
	input  logic [7:0] cr1,
	output logic       room,
	pcu_out_if.source  egress
);
	import pcu_pkg::*;

	pcu_pair_t           q_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                pop;
	logic [QCNT_W-1:0]   cnt_after_pop;
	logic [QPTR_W-1:0]   wr_next;
	pcu_pair_t           pair0;
	pcu_pair_t           pair1;

	always_comb begin
		pop = egress.valid && egress.ready;
		cnt_after_pop = cnt_q - {{(QCNT_W-1){1'b0}}, pop};
		// An item may bring two pairs, so two slots must be free.
		room = (cnt_after_pop <= QCNT_W'(QDEPTH - 2));
		wr_next = wr_q + 1'b1;
		pair0 = '{cb: cb0, cr: cr0, last: !two};
		pair1 = '{cb: cb1, cr: cr1, last: 1'b1};
		egress.valid = (cnt_q != '0);
		egress.cb_sample = q_q[rd_q].cb;
		egress.cr_sample = q_q[rd_q].cr;
		egress.last = q_q[rd_q].last;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= pair0;
			if (two) begin
				q_q[wr_next] <= pair1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push) begin
				wr_q <= wr_q + (two ? QPTR_W'(2) : QPTR_W'(1));
				cnt_q <= cnt_after_pop + (two ? QCNT_W'(2) : QCNT_W'(1));
			end else begin
				cnt_q <= cnt_after_pop;
			end
		end
	end

endmodule

>>> rtl/pcu_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcu_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [7:0]                  out_cb,
	input logic [7:0]                  out_cr,
	input logic                        out_last,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [pcu_pkg::PADDR_W-1:0] paddr,
	input logic [31:0]                 prdata
);

	// Ingress is only held off while pairs are waiting at the output.
	`ASSERT_CLK(a_stall_has_pending, clk, arst_n, !in_ready |-> out_valid, "ingress stalled with empty queue")

	// The second pair of a request is queued together with the first.
	`ASSERT_CLK(a_second_pair_ready, clk, arst_n, (out_valid && out_ready && !out_last) |=> out_valid, "second pair missing")

	// A stalled result keeps its payload.
	`ASSERT_CLK(a_hold_payload, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_cb) && $stable(out_cr) && $stable(out_last)), "stalled result changed")

	// The mode register reads back with its unused upper bits zero.
	`ASSERT_ALWAYS(a_mode_readback, clk, (psel && penable && !pwrite && paddr[2] == pcu_pkg::REG_MODE) |-> (prdata[31:2] == 30'd0), "mode readback upper bits set")

endmodule

bind packed_chroma_unpacker_top pcu_checker u_pcu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (ingress.ready),
	.out_valid (egress.valid),
	.out_ready (egress.ready),
	.out_cb    (egress.cb_sample),
	.out_cr    (egress.cr_sample),
	.out_last  (egress.last),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.prdata    (prdata)
);

>>> tb/sv/packed_chroma_unpacker_top_tb.sv
`timescale 1ns / 1ps

module packed_chroma_unpacker_top_tb;

	import pcu_pkg::*;

	// Code 3 of chroma_mode has no name in the package. The block treats it as 8-bit.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// The mode register sits at byte address 4 * REG_MODE.
	localparam logic [PADDR_W-1:0] MODE_ADDR = PADDR_W'(4 * REG_MODE);

	// The watchdog fires after this many cycles in which no request moves on either
	// channel. The slowest correct run has short random stalls and brief configuration
	// pauses, so this bound is far above any legal gap.
	localparam int unsigned STALL_LIMIT = 4000;

	// With the queue empty, the first pair shows up in the cycle after its request is
	// accepted. This is a generous settle time before a register write and before the final verdict.
	localparam int unsigned SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n;

	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	pcu_in_if in_ch ();
	pcu_out_if out_ch ();

	packed_chroma_unpacker_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.ingress (in_ch),
		.egress  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// The clock has a 20 ns period. It starts low, so no edge falls at time zero.
	always begin
		#10 clk = 1'b1;
		#10 clk = 0;
	end

	// This is the shadow state of the unpacker. It mirrors the mode register, the
	// leftover bits of both planes and the number of valid leftover bits.
	logic [1:0] cur_mode;
	logic [3:0] cb_left;
	logic [3:0] cr_left;
	logic [2:0] left_cnt;

	// These are the sample pairs still owed by the block, oldest first.
	pcu_pair_t expected_pairs[$];

	int unsigned mismatch_count;
	int unsigned stall_cycles;

	// When a calm flag is set, that side never idles. This gives long stretches that
	// run at full rate.
	bit tx_calm;
	bit rx_calm;

	// This is one 5-bit code taken out of the bit accumulator and scaled back to 8 bits.
	function automatic logic [7:0] expand_code(input logic [11:0] acc, input int unsigned sh);
		logic [11:0] shifted;
		shifted = acc >> sh;
		return {shifted[4:0], 3'b000};
	endfunction

	function automatic void push_pair(input logic [7:0] cb, input logic [7:0] cr,
		input logic fin);
		pcu_pair_t p;
		p.cb = cb;
		p.cr = cr;
		p.last = fin;
		expected_pairs.push_back(p);
	endfunction

	// This task works out the sample pairs that one accepted byte pair produces. It
	// also advances the shadow leftover state exactly as the unpacker does.
	task automatic predict_pairs(input logic [7:0] cb, input logic [7:0] cr, input logic rs);
		logic [11:0] acc_cb;
		logic [11:0] acc_cr;
		int unsigned nbits;
		int unsigned keep;
		// A plane start drops whatever bits were left over, whatever the mode.
		if (rs) begin
			cb_left = '0;
			cr_left = '0;
			left_cnt = '0;
		end
		if (cur_mode == MODE_5BIT) begin
			// The leftover bits sit above the new byte, so the MSB-first stream
			// is read from the top of the accumulator.
			nbits = left_cnt + 8;
			acc_cb = {cb_left, cb};
			acc_cr = {cr_left, cr};
			if (nbits >= 10) begin
				push_pair(expand_code(acc_cb, nbits - 5), expand_code(acc_cr, nbits - 5), 1'b0);
				push_pair(expand_code(acc_cb, nbits - 10), expand_code(acc_cr, nbits - 10),
					1'b1);
				keep = nbits - 10;
			end else begin
				push_pair(expand_code(acc_cb, nbits - 5), expand_code(acc_cr, nbits - 5), 1'b1);
				keep = nbits - 5;
			end
			cb_left = 4'(acc_cb & ((12'd1 << keep) - 12'd1));
			cr_left = 4'(acc_cr & ((12'd1 << keep) - 12'd1));
			left_cnt = 3'(keep);
		end else begin
			// Any mode other than the 5-bit stream throws the leftovers away.
			cb_left = '0;
			cr_left = '0;
			left_cnt = '0;
			if (cur_mode == MODE_4BIT) begin
				push_pair(cb & 8'hf0, cr & 8'hf0, 1'b0);
				push_pair({cb[3:0], 4'h0}, {cr[3:0], 4'h0}, 1'b1);
			end else begin
				// The 8-bit mode and the unused code both pass the bytes through.
				push_pair(cb, cr, 1'b1);
			end
		end
	endtask

	// This task sends one request on ingress. Sometimes it first idles for a few
	// cycles. Inputs change on the falling edge, and acceptance is seen on the
	// rising edge. Valid stays high into the next call when no idle is drawn.
	task automatic send_pair(input logic [7:0] cb, input logic [7:0] cr, input logic rs);
		int unsigned gap;
		gap = 0;
		if (!tx_calm && $urandom_range(0, 99) < 8)
			gap = $urandom_range(1, 3);
		if (gap != 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.cb_byte <= cb;
		in_ch.cr_byte <= cr;
		in_ch.restart <= rs;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_pairs(cb, cr, rs);
	endtask

	// This task stops sending and waits until every owed pair has come out. It then
	// lets a few more cycles pass so that the block is truly idle.
	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// This task reads the mode register back over APB and compares it with the shadow copy.
	task automatic check_mode_readback();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= MODE_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[1:0] !== cur_mode) begin
			$display("%0t mode readback: expected %0d actual %0d", $time, cur_mode,
				prdata[1:0]);
			mismatch_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// This task writes chroma_mode over APB, but only once the block is idle. The
	// write lands on the rising edge of the access cycle.
	task automatic write_mode(input logic [1:0] m);
		wait_idle();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MODE_ADDR;
		pwdata <= {30'd0, m};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		cur_mode = m;
		check_mode_readback();
	endtask

	// This task sends random planes. Most of them open with a restart, as a real
	// plane does. The payload is random, and a stray restart lands in the middle now
	// and then.
	task automatic send_random_planes(input int unsigned count, input int unsigned plane_max);
		int unsigned sent;
		int unsigned plane_len;
		logic rs;
		sent = 0;
		while (sent < count) begin
			plane_len = $urandom_range(1, plane_max);
			for (int unsigned i = 0; i < plane_len && sent < count; i++) begin
				if (i == 0)
					rs = ($urandom_range(0, 9) != 0);
				else
					rs = ($urandom_range(0, 99) < 2);
				send_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), rs);
				sent++;
			end
		end
	endtask

	// Right after reset, the mode must read back as the 5-bit stream and the
	// leftover state must be empty, so a stream without a restart starts clean.
	task automatic test_reset_state();
		check_mode_readback();
		send_pair(8'hff, 8'h00, 1'b0);
		send_pair(8'h00, 8'hff, 1'b0);
		send_pair(8'ha5, 8'h5a, 1'b0);
	endtask

	// In 8-bit mode every byte is one sample with last set. This covers the extreme bytes.
	task automatic test_8bit_passthrough();
		write_mode(MODE_8BIT);
		send_pair(8'h00, 8'hff, 1'b1);
		send_pair(8'hff, 8'h00, 1'b0);
		send_pair(8'h5a, 8'ha5, 1'b0);
	endtask

	// In 4-bit mode the high nibble comes out first, then the low nibble, and only
	// the second pair carries last.
	task automatic test_4bit_nibbles();
		write_mode(MODE_4BIT);
		send_pair(8'hf0, 8'h0f, 1'b1);
		send_pair(8'h0f, 8'hf0, 1'b0);
		send_pair(8'hff, 8'h00, 1'b0);
	endtask

	// This stream walks the bit count through every value from 8 to 12, so both the
	// one-pair case and the two-pair case come up. A restart then comes in the middle
	// of the stream, at a point where no leftover bits are pending.
	task automatic test_5bit_stream();
		write_mode(MODE_5BIT);
		send_pair(8'hff, 8'h00, 1'b1);
		send_pair(8'hff, 8'h00, 1'b0);
		send_pair(8'h00, 8'hff, 1'b0);
		send_pair(8'haa, 8'h55, 1'b0);
		send_pair(8'h5a, 8'hc3, 1'b0);
		send_pair(8'he7, 8'h18, 1'b1);
		send_pair(8'hff, 8'hff, 1'b0);
	endtask

	// The unused mode code must behave as plain 8-bit passthrough.
	task automatic test_unused_mode();
		write_mode(MODE_UNUSED);
		send_pair(8'hff, 8'h00, 1'b0);
		send_pair(8'h12, 8'hed, 1'b1);
	endtask

	// Here the stream leaves 5-bit mode with bits still pending. When 5-bit mode
	// comes back without a restart, those bits must be gone.
	task automatic test_leave_5bit();
		write_mode(MODE_5BIT);
		send_pair(8'hff, 8'hff, 1'b1);
		send_pair(8'h00, 8'h00, 1'b0);
		write_mode(MODE_8BIT);
		send_pair(8'h3c, 8'hc3, 1'b0);
		write_mode(MODE_5BIT);
		send_pair(8'hff, 8'h00, 1'b0);
		send_pair(8'h0f, 8'hf0, 1'b0);
	endtask

	// This is the bulk of the 5-bit stream traffic, with random idling on both sides.
	task automatic test_random_streams();
		write_mode(MODE_5BIT);
		send_random_planes(600, 40);
	endtask

	// This task steps through every mode, the extremes among them, and sends random
	// planes in each one. Some planes resume without a restart after a mode change.
	task automatic test_random_modes();
		logic [1:0] mode_seq[8];
		mode_seq = '{MODE_8BIT, MODE_4BIT, MODE_UNUSED, MODE_5BIT,
			MODE_4BIT, MODE_5BIT, MODE_8BIT, MODE_5BIT};
		foreach (mode_seq[i]) begin
			write_mode(mode_seq[i]);
			send_random_planes(60, 20);
		end
	endtask

	// This is a long stretch with no idling on either side. The 4-bit half keeps the
	// egress channel busy on every cycle.
	task automatic test_full_rate();
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		write_mode(MODE_5BIT);
		send_random_planes(150, 60);
		write_mode(MODE_4BIT);
		send_random_planes(150, 60);
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// Here the sender holds off until every owed pair has drained, then resumes the
	// stream with new random planes, most of which open with a restart.
	task automatic test_drain_pause();
		write_mode(MODE_5BIT);
		send_random_planes(40, 40);
		wait_idle();
		send_random_planes(40, 40);
	endtask

	// The receiver drops ready on about one cycle in ten, unless the calm flag is set.
	always @(negedge clk) begin
		out_ch.ready <= rx_calm ? 1'b1 : ($urandom_range(0, 99) >= 10);
	end

	// Each pair accepted on egress is checked against the oldest owed pair.
	always @(posedge clk) begin
		pcu_pair_t got;
		pcu_pair_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.cb_sample, out_ch.cr_sample, out_ch.last};
			if (expected_pairs.size() == 0) begin
				$display("%0t unexpected pair: expected none actual cb=%h cr=%h last=%b",
					$time, got.cb, got.cr, got.last);
				mismatch_count++;
			end else begin
				want = expected_pairs.pop_front();
				if (got !== want) begin
					$display("%0t pair mismatch: expected cb=%h cr=%h last=%b actual cb=%h cr=%h last=%b",
						$time, want.cb, want.cr, want.last, got.cb, got.cr, got.last);
					mismatch_count++;
				end
			end
		end
	end

	// The watchdog counts cycles in which neither channel moves a request.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles + 1 >= STALL_LIMIT) begin
			$display("%0t watchdog: no traffic for %0d cycles", $time, STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		// Every input of the block gets a known value at time zero.
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.cb_byte = '0;
		in_ch.cr_byte = '0;
		in_ch.restart = 1'b0;
		out_ch.ready = 1'b0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		mismatch_count = 0;
		stall_cycles = 0;

		// The shadow state starts at its reset values.
		cur_mode = MODE_RESET;
		cb_left = '0;
		cr_left = '0;
		left_cnt = '0;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_reset_state();
		test_8bit_passthrough();
		test_4bit_nibbles();
		test_5bit_stream();
		test_unused_mode();
		test_leave_5bit();
		test_random_streams();
		test_random_modes();
		test_full_rate();
		test_drain_pause();

		// Let the last pairs drain. The watchdog bounds this wait.
		wait_idle();

		if (expected_pairs.size() != 0) begin
			$display("%0t %0d expected pairs never arrived", $time, expected_pairs.size());
			mismatch_count++;
		end

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
